// ----- rtl/gpcc_pkg.sv -----
// Package: shared types, constants and command/status structs for the collision checker
package gpcc_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int MAX_SIDE_DEF   = 8;
    localparam int COORD_W        = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_CHECK = 2'd1;
    localparam logic [1:0] MODE_PLACE = 2'd2;

    localparam logic [1:0] VERDICT_FITS  = 2'd0;
    localparam logic [1:0] VERDICT_RANGE = 2'd1;
    localparam logic [1:0] VERDICT_ITEM  = 2'd2;
    localparam logic [1:0] VERDICT_NEST  = 2'd3;

    localparam logic [2:0] REG_ITEM_RADIUS = 3'd0;
    localparam logic [2:0] REG_NEST_RADIUS = 3'd1;
    localparam logic [2:0] REG_NEST_X      = 3'd2;
    localparam logic [2:0] REG_NEST_Y      = 3'd3;
    localparam logic [2:0] REG_X_MIN       = 3'd4;
    localparam logic [2:0] REG_X_MAX       = 3'd5;
    localparam logic [2:0] REG_Y_MIN       = 3'd6;
    localparam logic [2:0] REG_Y_MAX       = 3'd7;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [23:0] corner_x;
        logic signed [23:0] corner_y;
        logic [3:0]         grid_rows;
        logic [3:0]         grid_cols;
    } in_item_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [8:0] stored_count;
        logic       store_full;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture input item, reset cell indices
        logic bounds;      // evaluate bounds test (registered)
        logic cell_init;   // compute cell position of current indices
        logic pt_read;     // issue store read at point index
        logic pt_cmp;      // compare returned point
        logic nest_cmp;    // compare cell against nest
        logic pt_next;     // advance point index
        logic cell_next;   // advance cell indices, clear point index
        logic write_cell;  // append current cell to store
        logic clear;       // empty store
    } cmd_t;

    // Status back to the controller
    typedef struct packed {
        logic       out_of_range;
        logic       hit;        // latest compare hit
        logic       pt_last;    // point index at last stored point
        logic       no_points;  // store empty
        logic       cell_last;  // current cell is the last
        logic       no_cells;   // grid has no cells
        logic       full;       // store cannot take another point
        logic [1:0] mode;
    } stat_t;

endpackage

// ----- rtl/gpcc_datapath.sv -----
// Datapath: configuration registers, point store, cell generator and distance comparators
module gpcc_datapath #(
    parameter int MAX_POINTS = gpcc_pkg::MAX_POINTS_DEF,
    parameter int MAX_SIDE   = gpcc_pkg::MAX_SIDE_DEF,
    parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gpcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpcc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  gpcc_pkg::in_item_t            item,
    input  gpcc_pkg::cmd_t                cmd,
    output gpcc_pkg::stat_t               stat,
    output logic [CNT_W-1:0]              count
);

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SIDEW = $clog2(MAX_SIDE + 1);
    localparam int IDXW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    // Configuration registers
    logic [15:0]        item_radius_reg;
    logic [17:0]        nest_radius_reg;
    logic signed [23:0] nest_x_reg, nest_y_reg;
    logic signed [23:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_radius_reg <= 16'd3277;
            nest_radius_reg <= 18'd16384;
            nest_x_reg      <= '0;
            nest_y_reg      <= '0;
            x_min_reg       <= -24'sd655360;
            x_max_reg       <= 24'sd655360;
            y_min_reg       <= -24'sd655360;
            y_max_reg       <= 24'sd655360;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gpcc_pkg::REG_ITEM_RADIUS: item_radius_reg <= cfg_data[15:0];
                gpcc_pkg::REG_NEST_RADIUS: nest_radius_reg <= cfg_data[17:0];
                gpcc_pkg::REG_NEST_X:      nest_x_reg      <= cfg_data[23:0];
                gpcc_pkg::REG_NEST_Y:      nest_y_reg      <= cfg_data[23:0];
                gpcc_pkg::REG_X_MIN:       x_min_reg       <= cfg_data[23:0];
                gpcc_pkg::REG_X_MAX:       x_max_reg       <= cfg_data[23:0];
                gpcc_pkg::REG_Y_MIN:       y_min_reg       <= cfg_data[23:0];
                gpcc_pkg::REG_Y_MAX:       y_max_reg       <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Captured item
    logic signed [23:0] cx_reg, cy_reg;
    logic [SIDEW-1:0]   rows_reg, cols_reg;
    logic [1:0]         mode_reg;
    logic [IDXW-1:0]    j_reg, k_reg;
    logic [CNT_W-1:0]   count_reg, pidx_reg;

    logic [SIDEW-1:0] rows_sat, cols_sat;
    always_comb
    begin
        rows_sat = (32'(item.grid_rows) > MAX_SIDE) ? SIDEW'(MAX_SIDE) : SIDEW'(item.grid_rows);
        cols_sat = (32'(item.grid_cols) > MAX_SIDE) ? SIDEW'(MAX_SIDE) : SIDEW'(item.grid_cols);
    end

    // Step of three radii, 18 bits
    logic [17:0] step;
    assign step = {2'b00, item_radius_reg} + {1'b0, item_radius_reg, 1'b0};

    // Bounds test, registered
    logic signed [30:0] span_x, span_y;
    logic signed [31:0] bx_lo, bx_hi, by_lo, by_hi, lx, hx, ly, hy;
    logic               oor_reg;
    always_comb
    begin
        span_x = 31'($signed({1'b0, step}) * $signed({1'b0, cols_reg}));
        span_y = 31'($signed({1'b0, step}) * $signed({1'b0, rows_reg}));
        bx_lo  = 32'(cx_reg) - 32'($signed({1'b0, item_radius_reg}));
        lx     = 32'(x_min_reg) + 32'($signed({1'b0, item_radius_reg}));
        bx_hi  = 32'(cx_reg) + 32'($signed({1'b0, item_radius_reg})) + 32'(span_x);
        hx     = 32'(x_max_reg) - 32'($signed({1'b0, item_radius_reg}));
        by_lo  = 32'(cy_reg) - 32'($signed({1'b0, item_radius_reg}));
        ly     = 32'(y_min_reg) + 32'($signed({1'b0, item_radius_reg}));
        by_hi  = 32'(cy_reg) + 32'($signed({1'b0, item_radius_reg})) + 32'(span_y);
        hy     = 32'(y_max_reg) - 32'($signed({1'b0, item_radius_reg}));
    end

    // Cell position (unsaturated, 32 bits signed covers the 24-bit corner plus the 18-bit step times the cell index)
    logic signed [31:0] px_reg, py_reg;
    logic signed [31:0] px_calc, py_calc;
    always_comb
    begin
        px_calc = 32'(cx_reg) + 32'($signed({1'b0, step}) * $signed({1'b0, k_reg}));
        py_calc = 32'(cy_reg) + 32'($signed({1'b0, step}) * $signed({1'b0, j_reg}));
    end

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607)
            sat24 = 24'sh7FFFFF;
        else if (v < -32'sd8388608)
            sat24 = 24'sh800000;
        else
            sat24 = v[23:0];
    endfunction

    // Point store
    logic [47:0] store_mem [MAX_POINTS];
    logic [47:0] rd_data_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.write_cell && (count_reg < CNT_W'(MAX_POINTS)))
            store_mem[count_reg[AW-1:0]] <= {sat24(px_reg), sat24(py_reg)};
        if (cmd.pt_read)
            rd_data_reg <= store_mem[pidx_reg[AW-1:0]];
    end

    // Distance squares: one per axis, registered, then sum compared
    logic signed [32:0] dx, dy;
    logic signed [65:0] dx_sq, dy_sq;
    logic [63:0]        dx2_reg, dy2_reg;
    logic               cmp_nest_reg, cmp_valid_reg;
    logic [33:0]        lim_item;
    logic [37:0]        lim_nest;
    logic [18:0]        nr_sum;
    logic               hit_reg;

    always_comb
    begin
        if (cmd.nest_cmp)
        begin
            dx = 33'(px_reg) - 33'(nest_x_reg);
            dy = 33'(py_reg) - 33'(nest_y_reg);
        end
        else
        begin
            dx = 33'(px_reg) - 33'($signed(rd_data_reg[47:24]));
            dy = 33'(py_reg) - 33'($signed(rd_data_reg[23:0]));
        end
        dx_sq    = dx * dx;
        dy_sq    = dy * dy;
        lim_item = {item_radius_reg, 1'b0} * {item_radius_reg, 1'b0};
        nr_sum   = {1'b0, nest_radius_reg} + 19'(item_radius_reg);
        lim_nest = nr_sum * nr_sum;
    end

    always_ff @(posedge clk)
    begin
        dx2_reg <= 64'(dx_sq);
        dy2_reg <= 64'(dy_sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= gpcc_pkg::MODE_CLEAR;
            count_reg     <= '0;
            pidx_reg      <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_nest_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            oor_reg       <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.pt_cmp || cmd.nest_cmp;
            cmp_nest_reg  <= cmd.nest_cmp;
            if (cmp_valid_reg)
                hit_reg <= cmp_nest_reg ? ((dx2_reg + dy2_reg) < 64'(lim_nest))
                                        : ((dx2_reg + dy2_reg) < 64'(lim_item));
            else if (cmd.load)
                hit_reg <= 1'b0;
            if (cmd.load)
            begin
                mode_reg <= item.mode;
                j_reg    <= '0;
                k_reg    <= '0;
                pidx_reg <= '0;
            end
            if (cmd.bounds)
                oor_reg <= (bx_lo < lx) || (bx_hi > hx) || (by_lo < ly) || (by_hi > hy);
            if (cmd.pt_next)
                pidx_reg <= pidx_reg + 1'b1;
            if (cmd.cell_next)
            begin
                pidx_reg <= '0;
                if (32'(k_reg) + 1 >= 32'(cols_reg))
                begin
                    k_reg <= '0;
                    j_reg <= j_reg + 1'b1;
                end
                else
                    k_reg <= k_reg + 1'b1;
            end
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.write_cell && (count_reg < CNT_W'(MAX_POINTS)))
                count_reg <= count_reg + 1'b1;
        end
    end

    // Payload captures
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg   <= item.corner_x;
            cy_reg   <= item.corner_y;
            rows_reg <= rows_sat;
            cols_reg <= cols_sat;
        end
        if (cmd.cell_init)
        begin
            px_reg <= px_calc;
            py_reg <= py_calc;
        end
    end

    always_comb
    begin
        stat.out_of_range = oor_reg;
        stat.hit          = hit_reg;
        stat.pt_last      = (32'(pidx_reg) + 1 >= 32'(count_reg));
        stat.no_points    = (count_reg == '0);
        stat.cell_last    = (32'(k_reg) + 1 >= 32'(cols_reg)) &&
                            (32'(j_reg) + 1 >= 32'(rows_reg));
        stat.no_cells     = (rows_reg == '0) || (cols_reg == '0);
        stat.full         = (count_reg >= CNT_W'(MAX_POINTS));
        stat.mode         = mode_reg;
    end

    assign count = count_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (count_reg == '0))
        else $error("clear did not empty store");
    a_cmp_follow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pt_cmp |=> cmp_valid_reg && !cmp_nest_reg)
        else $error("point compare not staged");
`endif

endmodule

// ----- rtl/gpcc_ctrl.sv -----
// Controller: sequences clear, check and place over cells and stored points
module gpcc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  gpcc_pkg::stat_t     stat,
    output gpcc_pkg::cmd_t      cmd,
    output logic                result_load,
    output logic [1:0]          verdict
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_BCHK   = 4'd2;
    localparam logic [3:0] S_CELL   = 4'd3;
    localparam logic [3:0] S_RD     = 4'd4;
    localparam logic [3:0] S_CMP    = 4'd5;
    localparam logic [3:0] S_SQ     = 4'd6;
    localparam logic [3:0] S_HIT    = 4'd7;
    localparam logic [3:0] S_NSQ    = 4'd8;
    localparam logic [3:0] S_NHIT   = 4'd9;
    localparam logic [3:0] S_PCELL  = 4'd10;
    localparam logic [3:0] S_PWR    = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;
    localparam logic [3:0] S_NCMP   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] verdict_reg, verdict_next;
    logic       out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    always_comb
    begin
        state_next     = state_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg && out_stall;
        result_load    = 1'b0;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load     = 1'b1;
                    verdict_next = gpcc_pkg::VERDICT_FITS;
                    state_next   = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.mode)
                    gpcc_pkg::MODE_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                    gpcc_pkg::MODE_CHECK:
                    begin
                        cmd.bounds = 1'b1;
                        state_next = S_BCHK;
                    end
                    gpcc_pkg::MODE_PLACE: state_next = stat.no_cells ? S_DONE : S_PCELL;
                    default: state_next = S_DONE;
                endcase
            end
            S_BCHK:
            begin
                if (stat.out_of_range)
                begin
                    verdict_next = gpcc_pkg::VERDICT_RANGE;
                    state_next   = S_DONE;
                end
                else if (stat.no_cells)
                    state_next = S_DONE;
                else
                    state_next = S_CELL;
            end
            S_CELL:
            begin
                cmd.cell_init = 1'b1;
                state_next    = stat.no_points ? S_NCMP : S_RD;
            end
            S_RD:
            begin
                cmd.pt_read = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                cmd.pt_cmp = 1'b1;
                state_next = S_SQ;
            end
            S_SQ: state_next = S_HIT;
            S_HIT:
            begin
                if (stat.hit)
                begin
                    verdict_next = gpcc_pkg::VERDICT_ITEM;
                    state_next   = S_DONE;
                end
                else if (stat.pt_last)
                    state_next = S_NCMP;
                else
                begin
                    cmd.pt_next = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_NCMP:
            begin
                cmd.nest_cmp = 1'b1;
                state_next   = S_NSQ;
            end
            S_NSQ: state_next = S_NHIT;
            S_NHIT:
            begin
                if (stat.hit)
                begin
                    verdict_next = gpcc_pkg::VERDICT_NEST;
                    state_next   = S_DONE;
                end
                else if (stat.cell_last)
                    state_next = S_DONE;
                else
                begin
                    cmd.cell_next = 1'b1;
                    state_next    = S_CELL;
                end
            end
            S_PCELL:
            begin
                cmd.cell_init = 1'b1;
                state_next    = S_PWR;
            end
            S_PWR:
            begin
                cmd.write_cell = 1'b1;
                if (stat.full)
                    verdict_next = verdict_reg;
                if (stat.cell_last)
                    state_next = S_DONE;
                else
                begin
                    cmd.cell_next = 1'b1;
                    state_next    = S_PCELL;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free or being transferred
                if (!out_valid_reg || !out_stall)
                begin
                    result_load    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            verdict_reg   <= gpcc_pkg::VERDICT_FITS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input open while busy");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (!out_valid_reg || !out_stall)) |=> out_valid_reg)
        else $error("result not presented");
    a_one_hot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.clear, cmd.write_cell, cmd.pt_read, cmd.nest_cmp}))
        else $error("conflicting commands");
`endif

endmodule

// ----- rtl/grid_placement_collision_checker_top.sv -----
// Top level: grid placement collision checker
//
// Input channel in_valid/in_stall carries one item (mode, corner, grid size);
// output channel out_valid/out_stall returns one result per item.
// A transfer happens on a rising edge with valid high and stall low.
// Configuration: cfg_we, cfg_index and cfg_data write one register a cycle;
// the user must write only while the block is idle; the block does not enforce it.
// One item is in flight at a time. Clear goes from dispatch to done; place
// computes each cell's position and then writes it to the store. Check runs
// the bounds test, then for each cell reads, compares, squares and tests
// every stored point in turn and then compares against the nest, as set by the
// single store read port and the registered square-and-compare loop.
// A result waits in its output register while out_stall is high; the next
// item is still taken and processed, and its result is held back until the
// waiting one has been transferred.
// Reset empties the store (count to zero) and loads the register defaults;
// store contents are not cleared.
module grid_placement_collision_checker_top #(
    parameter int MAX_POINTS = gpcc_pkg::MAX_POINTS_DEF,
    parameter int MAX_SIDE   = gpcc_pkg::MAX_SIDE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gpcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpcc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  gpcc_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output gpcc_pkg::out_item_t             out_data
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    gpcc_pkg::cmd_t      cmd;
    gpcc_pkg::stat_t     stat;
    logic [CNT_W-1:0]    count;
    logic [1:0]          verdict;
    logic                result_load;
    logic                full_reg;
    gpcc_pkg::out_item_t out_data_reg;

    gpcc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .stat        (stat),
        .cmd         (cmd),
        .result_load (result_load),
        .verdict     (verdict)
    );

    gpcc_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_SIDE   (MAX_SIDE),
        .CNT_W      (CNT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .count     (count)
    );

    // Flag dropped points during place
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (cmd.load)
            full_reg <= 1'b0;
        else if (cmd.write_cell && stat.full)
            full_reg <= 1'b1;
    end

    // Hold the finished result for transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_data_reg <= '0;
        else if (result_load)
        begin
            out_data_reg.verdict      <= verdict;
            out_data_reg.stored_count <= 9'(count);
            out_data_reg.store_full   <= full_reg;
        end
    end

    assign out_data = out_data_reg;

endmodule
